// ===== hw/rtl/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types, constants and helper functions of the bounded stack with
// search: request and response payloads, request kinds, status codes and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 5;
	localparam int KIND_W = 2;
	localparam int IDX_W  = 4;
	localparam int DATA_W = 32;
	localparam int STAT_W = 3;
	localparam int POS_W  = 4;
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CAP_W-1:0]     cap_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         index;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] data;
		logic [POS_W-1:0]         position;
	} rsp_t;

	typedef struct packed {
		logic load_req;
		logic start;
		logic read_done;
		logic scan;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              full;
		logic              empty;
		logic              bad_index;
		logic              match;
		logic              scan_end;
		logic              out_free;
	} dp_sts_t;

	function automatic logic [DATA_W-1:0] widen(word_t w);
		logic signed [WORD_BITS-1:0] s;
		logic signed [63:0]          e;
		s = signed'(w);
		e = 64'(s);
		return e[DATA_W-1:0];
	endfunction

	function automatic word_t narrow(logic signed [DATA_W-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		return e[WORD_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/bounded_stack_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_search
// Fixed-depth LIFO stack of signed words with push, pop, get by index and
// search for the lowest matching index, with a writable capacity limit.
//
//   channel  valid      stall      payload
//   request  req_valid  req_stall  req_data (kind, value, index)
//   response rsp_valid  rsp_stall  rsp_data (status, data, position)
//   config   cfg_we     -          cfg_data (capacity limit)
//
// one request at a time: push and requests refused at execute (full, empty,
// bad index) go from execute straight to the result state, pop and get pass
// a read state, search a scan state (one RAM read per entry)
// the response register frees the core once a result is loaded into it
// arst_n clears fill count, capacity limit (to 16) and the state machine
// a stalled response holds the core in its result state until taken
// ----------------------------------------------------------------------------
module bounded_stack_with_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bss_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bss_pkg::rsp_t rsp_data,
	input  logic          cfg_we,
	input  bss_pkg::cap_t cfg_data
);
	import bss_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	bss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== hw/rtl/bss_ram.sv =====
// ----------------------------------------------------------------------------
// bss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bss_ram #(
	parameter int WIDTH   = 32,
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(ENTRIES)-1:0] waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(ENTRIES)-1:0] raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/bss_ctrl.sv =====
// ----------------------------------------------------------------------------
// bss_ctrl
// Controller of the bounded stack: takes one request at a time, steps the
// datapath through execute, read or scan, and hands the response out.
// ----------------------------------------------------------------------------
module bss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  bss_pkg::dp_sts_t sts,
	output bss_pkg::dp_cmd_t cmd
);
	import bss_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_READ   = 5'b00100,
		S_SCAN   = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.start = 1'b1;
				case (sts.kind)
					KIND_PUSH:   state_d = S_RESULT;
					KIND_POP:    state_d = sts.empty ? S_RESULT : S_READ;
					KIND_GET:    state_d = sts.bad_index ? S_RESULT : S_READ;
					KIND_SEARCH: state_d = sts.empty ? S_RESULT : S_SCAN;
					default:     state_d = S_RESULT;
				endcase
			end
			S_READ: begin
				cmd.read_done = 1'b1;
				state_d       = S_RESULT;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.match || sts.scan_end) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/bss_dp.sv =====
// ----------------------------------------------------------------------------
// bss_dp
// Datapath of the bounded stack: entry RAM, fill count, capacity register,
// request and response registers, search counter and comparator, output
// register.
// ----------------------------------------------------------------------------
module bss_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  bss_pkg::req_t    req_data,
	input  logic             rsp_stall,
	output logic             rsp_valid,
	output bss_pkg::rsp_t    rsp_data,
	input  logic             cfg_we,
	input  bss_pkg::cap_t    cfg_data,
	input  bss_pkg::dp_cmd_t cmd,
	output bss_pkg::dp_sts_t sts
);
	import bss_pkg::*;

	logic [KIND_W-1:0] kind_q;
	word_t             word_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  fill_q;
	cap_t              cap_q;
	logic [CNT_W-1:0]  scan_q;
	rsp_t              res_q;
	rsp_t              out_q;
	logic              out_valid_q;

	logic [CMP_W-1:0]  fill_ext;
	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  idx_ext;
	logic [CMP_W-1:0]  depth_ext;
	logic [CMP_W-1:0]  scan_prev;
	logic [CNT_W-1:0]  fill_m1;
	logic              full;
	logic              empty;
	logic              bad_index;

	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	word_t             ram_rdata;

	assign fill_ext  = CMP_W'(fill_q);
	assign cap_ext   = CMP_W'(cap_q);
	assign idx_ext   = CMP_W'(idx_q);
	assign depth_ext = CMP_W'(DEPTH);
	assign scan_prev = CMP_W'(scan_q - 1'b1);
	assign fill_m1   = fill_q - 1'b1;

	assign full      = (fill_ext >= cap_ext) || (fill_ext >= depth_ext);
	assign empty     = (fill_q == '0);
	assign bad_index = (idx_ext >= fill_ext) || (idx_ext >= depth_ext);

	assign sts.kind      = kind_q;
	assign sts.full      = full;
	assign sts.empty     = empty;
	assign sts.bad_index = bad_index;
	assign sts.match     = (ram_rdata == word_q);
	assign sts.scan_end  = (scan_q == fill_q);
	assign sts.out_free  = !out_valid_q || !rsp_stall;

	// entry store
	assign ram_we = cmd.start && (kind_q == KIND_PUSH) && !full;
	assign ram_re = cmd.start || cmd.scan;

	always_comb begin
		ram_raddr = scan_q[ADDR_W-1:0];
		if (cmd.start) begin
			case (kind_q)
				KIND_POP: ram_raddr = fill_m1[ADDR_W-1:0];
				KIND_GET: ram_raddr = idx_ext[ADDR_W-1:0];
				default:  ram_raddr = '0;
			endcase
		end
	end

	bss_ram #(
		.WIDTH   (WORD_BITS),
		.ENTRIES (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (word_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.start) begin
				if ((kind_q == KIND_PUSH) && !full) begin
					fill_q <= fill_q + 1'b1;
				end else if ((kind_q == KIND_POP) && !empty) begin
					fill_q <= fill_m1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, scan and response registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= req_data.kind;
			word_q <= narrow(req_data.value);
			idx_q  <= req_data.index;
		end
		if (cmd.start) begin
			res_q.data     <= '0;
			res_q.position <= '0;
			scan_q         <= CNT_W'(1);
			case (kind_q)
				KIND_PUSH: res_q.status <= full ? ST_FULL : ST_OK;
				KIND_POP:  res_q.status <= empty ? ST_EMPTY : ST_OK;
				KIND_GET:  res_q.status <= bad_index ? ST_BAD_INDEX : ST_OK;
				default:   res_q.status <= ST_NOT_FOUND;
			endcase
		end
		if (cmd.read_done) begin
			res_q.data <= widen(ram_rdata);
		end
		if (cmd.scan) begin
			if (sts.match) begin
				res_q.status   <= ST_OK;
				res_q.position <= scan_prev[POS_W-1:0];
			end else if (!sts.scan_end) begin
				scan_q <= scan_q + 1'b1;
			end
		end
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.start |=> $stable(fill_q))
		else $error("fill count changed outside execute");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.emit))
		else $error("response valid without emit");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (scan_q != '0) && (scan_q <= fill_q))
		else $error("search counter out of range");
`endif

endmodule
